@@ rtl/core/cec_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cec_pkg: shared types and constants of the collision event coalescer
// Field widths, result codes, item structs, controller states and the
// command and status groups that join the controller to the datapath.
// ----------------------------------------------------------------------------
package cec_pkg;

  // Fixed field widths.
  localparam int STEP_BITS = 24;
  localparam int ID_BITS   = 16;
  localparam int GAP_BITS  = 24;
  localparam int PAIR_BITS = 2 * ID_BITS;

  // Width of end step plus gap, wide enough that the sum never wraps.
  localparam int SUM_BITS = ((STEP_BITS > GAP_BITS) ? STEP_BITS : GAP_BITS) + 1;

  // Default depth of the interval table.
  localparam int PAIR_SLOTS_DEFAULT = 32;

  // Input operation codes.
  typedef enum logic [0:0] {
    OP_RECORD = 1'b0,
    OP_FLUSH  = 1'b1
  } op_t;

  // Result status codes.
  typedef enum logic [1:0] {
    STATUS_EVENT   = 2'd0,
    STATUS_DROPPED = 2'd1,
    STATUS_EMPTY   = 2'd2
  } status_t;

  // One input item.
  typedef struct packed {
    op_t                  op;
    logic [STEP_BITS-1:0] step;
    logic [ID_BITS-1:0]   first_id;
    logic [ID_BITS-1:0]   second_id;
  } in_item_t;

  // One result item.
  typedef struct packed {
    status_t              status;
    logic [STEP_BITS-1:0] begin_step;
    logic [STEP_BITS-1:0] end_step;
    logic [ID_BITS-1:0]   pair_first;
    logic [ID_BITS-1:0]   pair_second;
    logic                 last;
  } out_item_t;

  // Controller states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_UPDATE,
    S_SCAN,
    S_EMIT,
    S_EMPTY
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;        // capture the accepted item and its match results
    logic rec_commit;  // apply the record update and emit its result if any
    logic scan_start;  // restart the minimum search at slot zero
    logic scan_step;   // examine one slot of the minimum search
    logic flush_emit;  // emit the smallest open interval and close it
    logic empty_emit;  // emit the empty flush result
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic hit;         // record pair is in the table
    logic free_avail;  // a free slot exists for a new pair
    logic past_gap;    // record step lies beyond end plus gap
    logic count_zero;  // no open interval
    logic count_one;   // exactly one open interval
    logic scan_last;   // search is at the last slot
    logic out_free;    // output register can take a result this cycle
  } stat_t;

endpackage
`default_nettype wire

@@ rtl/core/cec_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cec_ctrl: controller of the collision event coalescer
// Sequences record updates, the slot-by-slot flush search and the result
// handoff to the output register.
// ----------------------------------------------------------------------------
module cec_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  input  wire cec_pkg::op_t   in_op,
  input  wire cec_pkg::stat_t stat,
  output cec_pkg::cmd_t       cmd,
  output logic                in_stall
);

  cec_pkg::state_t state;
  cec_pkg::state_t state_next;
  logic            need_out;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cec_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // A record produces a result on a restart or when the table is full.
  assign need_out = (stat.hit && stat.past_gap) || (!stat.hit && !stat.free_avail);

  // Items are taken only between operations.
  assign in_stall = (state != cec_pkg::S_IDLE);

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      cec_pkg::S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          if (in_op == cec_pkg::OP_FLUSH) begin
            if (stat.count_zero) begin
              state_next = cec_pkg::S_EMPTY;
            end else begin
              cmd.scan_start = 1'b1;
              state_next     = cec_pkg::S_SCAN;
            end
          end else begin
            state_next = cec_pkg::S_UPDATE;
          end
        end
      end
      cec_pkg::S_UPDATE: begin
        if (!need_out || stat.out_free) begin
          cmd.rec_commit = 1'b1;
          state_next     = cec_pkg::S_IDLE;
        end
      end
      cec_pkg::S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.scan_last) begin
          state_next = cec_pkg::S_EMIT;
        end
      end
      cec_pkg::S_EMIT: begin
        if (stat.out_free) begin
          cmd.flush_emit = 1'b1;
          if (stat.count_one) begin
            state_next = cec_pkg::S_IDLE;
          end else begin
            cmd.scan_start = 1'b1;
            state_next     = cec_pkg::S_SCAN;
          end
        end
      end
      cec_pkg::S_EMPTY: begin
        if (stat.out_free) begin
          cmd.empty_emit = 1'b1;
          state_next     = cec_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = cec_pkg::S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

@@ rtl/core/cec_datapath.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cec_datapath: interval table and result path of the collision coalescer
// Holds the pair table with a parallel pair match, the gap compare, the
// sequential minimum search used by flush and the output register.
// ----------------------------------------------------------------------------
module cec_datapath #(
  parameter int PAIR_SLOTS = cec_pkg::PAIR_SLOTS_DEFAULT
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire cec_pkg::cmd_t                cmd,
  input  wire cec_pkg::in_item_t            in_item,
  input  wire logic [cec_pkg::GAP_BITS-1:0] min_gap,
  output cec_pkg::stat_t                    stat,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output cec_pkg::out_item_t                out_item
);

  localparam int IDX_BITS = (PAIR_SLOTS > 1) ? $clog2(PAIR_SLOTS) : 1;
  localparam int CNT_BITS = $clog2(PAIR_SLOTS + 1);

  // Interval table.
  logic [PAIR_SLOTS-1:0]         entry_valid;
  logic [cec_pkg::PAIR_BITS-1:0] entry_pair  [PAIR_SLOTS];
  logic [cec_pkg::STEP_BITS-1:0] entry_begin [PAIR_SLOTS];
  logic [cec_pkg::STEP_BITS-1:0] entry_end   [PAIR_SLOTS];
  logic [CNT_BITS-1:0]           valid_count;

  // Captured item and its match results.
  cec_pkg::in_item_t             item;
  logic                          hit;
  logic [IDX_BITS-1:0]           hit_idx;
  logic                          free_avail;
  logic [IDX_BITS-1:0]           free_idx;

  // Flush search.
  logic [IDX_BITS-1:0]           scan_idx;
  logic                          best_found;
  logic [IDX_BITS-1:0]           best_idx;
  logic [cec_pkg::PAIR_BITS-1:0] best_pair;
  logic [cec_pkg::STEP_BITS-1:0] best_begin;
  logic [cec_pkg::STEP_BITS-1:0] best_end;

  logic [cec_pkg::PAIR_BITS-1:0] in_pair;
  logic [cec_pkg::PAIR_BITS-1:0] item_pair;
  logic                          match_any;
  logic [IDX_BITS-1:0]           match_idx;
  logic                          free_any;
  logic [IDX_BITS-1:0]           free_first;
  logic [IDX_BITS-1:0]           rd_idx;
  logic [cec_pkg::PAIR_BITS-1:0] rd_pair;
  logic [cec_pkg::STEP_BITS-1:0] rd_begin;
  logic [cec_pkg::STEP_BITS-1:0] rd_end;
  logic [cec_pkg::SUM_BITS-1:0]  gap_limit;
  logic                          past_gap;
  logic                          take_best;
  logic                          rec_emit;
  logic                          emit;
  logic                          out_free;
  cec_pkg::out_item_t            result;

  assign in_pair   = {in_item.first_id, in_item.second_id};
  assign item_pair = {item.first_id, item.second_id};

  // Parallel pair match and lowest free slot, taken from the incoming item.
  always_comb begin
    match_any  = 1'b0;
    match_idx  = '0;
    free_any   = 1'b0;
    free_first = '0;
    for (int i = PAIR_SLOTS - 1; i >= 0; i--) begin
      if (entry_valid[i] && (entry_pair[i] == in_pair)) begin
        match_any = 1'b1;
        match_idx = IDX_BITS'(i);
      end
      if (!entry_valid[i]) begin
        free_any   = 1'b1;
        free_first = IDX_BITS'(i);
      end
    end
  end

  // Single table read port, shared by the record update and the flush search.
  assign rd_idx   = cmd.scan_step ? scan_idx : hit_idx;
  assign rd_pair  = entry_pair[rd_idx];
  assign rd_begin = entry_begin[rd_idx];
  assign rd_end   = entry_end[rd_idx];

  // Gap test without wrap-around.
  assign gap_limit = cec_pkg::SUM_BITS'(rd_end) + cec_pkg::SUM_BITS'(min_gap);
  assign past_gap  = cec_pkg::SUM_BITS'(item.step) > gap_limit;

  // An open slot is the best candidate if none is held or its pair is smaller.
  assign take_best = entry_valid[scan_idx] && (!best_found || (rd_pair < best_pair));

  // Result selection.
  assign rec_emit = cmd.rec_commit && ((hit && past_gap) || (!hit && !free_avail));
  assign emit     = rec_emit || cmd.flush_emit || cmd.empty_emit;
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    result = '0;
    priority if (cmd.flush_emit) begin
      result.status      = cec_pkg::STATUS_EVENT;
      result.begin_step  = best_begin;
      result.end_step    = best_end;
      result.pair_first  = best_pair[cec_pkg::PAIR_BITS-1:cec_pkg::ID_BITS];
      result.pair_second = best_pair[cec_pkg::ID_BITS-1:0];
      result.last        = (valid_count == CNT_BITS'(1));
    end else if (cmd.empty_emit) begin
      result.status = cec_pkg::STATUS_EMPTY;
      result.last   = 1'b1;
    end else begin
      result.status      = hit ? cec_pkg::STATUS_EVENT : cec_pkg::STATUS_DROPPED;
      result.begin_step  = hit ? rd_begin : item.step;
      result.end_step    = hit ? rd_end : item.step;
      result.pair_first  = item.first_id;
      result.pair_second = item.second_id;
      result.last        = 1'b1;
    end
  end

  // Item capture and match results.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item       <= in_item;
      hit        <= match_any;
      hit_idx    <= match_idx;
      free_avail <= free_any;
      free_idx   <= free_first;
    end
  end

  // Table contents.
  always_ff @(posedge clk) begin
    if (cmd.rec_commit) begin
      if (hit) begin
        entry_end[hit_idx] <= item.step;
        if (past_gap) begin
          entry_begin[hit_idx] <= item.step;
        end
      end else if (free_avail) begin
        entry_pair[free_idx]  <= item_pair;
        entry_begin[free_idx] <= item.step;
        entry_end[free_idx]   <= item.step;
      end
    end
  end

  // Valid bits and open interval count.
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
      valid_count <= '0;
    end else if (cmd.rec_commit && !hit && free_avail) begin
      entry_valid[free_idx] <= 1'b1;
      valid_count           <= valid_count + CNT_BITS'(1);
    end else if (cmd.flush_emit) begin
      entry_valid[best_idx] <= 1'b0;
      valid_count           <= valid_count - CNT_BITS'(1);
    end
  end

  // Minimum search over the slots, one slot per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_idx   <= '0;
      best_found <= 1'b0;
    end else if (cmd.scan_start) begin
      scan_idx   <= '0;
      best_found <= 1'b0;
    end else if (cmd.scan_step) begin
      scan_idx <= scan_idx + IDX_BITS'(1);
      if (take_best) begin
        best_found <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_step && take_best) begin
      best_idx   <= scan_idx;
      best_pair  <= rd_pair;
      best_begin <= rd_begin;
      best_end   <= rd_end;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_item <= result;
    end
  end

  // Status toward the controller.
  assign stat.hit        = hit;
  assign stat.free_avail = free_avail;
  assign stat.past_gap   = past_gap;
  assign stat.count_zero = (valid_count == '0);
  assign stat.count_one  = (valid_count == CNT_BITS'(1));
  assign stat.scan_last  = (scan_idx == IDX_BITS'(PAIR_SLOTS - 1));
  assign stat.out_free   = out_free;

  // The open interval count tracks the valid bits.
  a_count_matches: assert property (@(posedge clk) disable iff (rst)
    valid_count == CNT_BITS'($countones(entry_valid)))
    else $error("open interval count does not match the valid bits");

  // A result is never written over one that is still waiting.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    emit |-> out_free)
    else $error("result written while the output register is stalled");

  // A flush result always comes from a slot found by the search.
  a_flush_found: assert property (@(posedge clk) disable iff (rst)
    cmd.flush_emit |-> (best_found && entry_valid[best_idx]))
    else $error("flush emitted without an open interval selected");

endmodule
`default_nettype wire

@@ rtl/core/collision_event_coalescer.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// collision_event_coalescer: per-pair collision interval merge with gap
// Merges collision records into open intervals keyed by the ordered entity
// pair, emits intervals on a restart or on flush, and reports drops.
// ----------------------------------------------------------------------------
// When a collision record is accepted its pair is matched against every slot
// of the table at once, and from the registered match results the gap adder
// and compare decide between extend, restart, open or drop. A flush emits the
// open intervals in ascending pair order; the smallest pair is found each time
// by a search that reads one table slot per cycle, and a flush of an empty
// table emits a single empty result. Results wait in an output register, so a
// stalled output holds back the block only when a further result is due. The
// table needs no clearing after reset. The user must write min_gap only while
// the block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module collision_event_coalescer #(
  parameter int PAIR_SLOTS = cec_pkg::PAIR_SLOTS_DEFAULT
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_we,
  input  wire logic [cec_pkg::GAP_BITS-1:0] cfg_wdata,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire cec_pkg::in_item_t            in_item,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output cec_pkg::out_item_t                out_item
);

  logic [cec_pkg::GAP_BITS-1:0] min_gap;
  cec_pkg::cmd_t                cmd;
  cec_pkg::stat_t               stat;

  // Gap register.
  always_ff @(posedge clk) begin
    if (rst) begin
      min_gap <= '0;
    end else if (cfg_we) begin
      min_gap <= cfg_wdata;
    end
  end

  cec_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_op    (in_item.op),
    .stat     (stat),
    .cmd      (cmd),
    .in_stall (in_stall)
  );

  cec_datapath #(
    .PAIR_SLOTS (PAIR_SLOTS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .in_item   (in_item),
    .min_gap   (min_gap),
    .stat      (stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule
`default_nettype wire
